FILE: design/bldc_startup_sequencer_assert.svh
`ifndef BLDC_STARTUP_SEQUENCER_ASSERT_SVH
`define BLDC_STARTUP_SEQUENCER_ASSERT_SVH

// Implication within the same clock edge, held off while reset is asserted.
`define BLDCSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication from one clock edge to the next, held off while reset is asserted.
`define BLDCSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bldcss_pkg.sv
package bldcss_pkg;

	// Event kinds on the request channel.
	localparam logic [1:0] REQ_SET_MODE = 2'd0;
	localparam logic [1:0] REQ_TASK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT  = 2'd2;
	localparam logic [1:0] REQ_CLEAR    = 2'd3;

	// Requested modes.
	localparam logic [2:0] MODE_OFF   = 3'd0;
	localparam logic [2:0] MODE_BRAKE = 3'd1;
	localparam logic [2:0] MODE_FREE  = 3'd2;
	localparam logic [2:0] MODE_PID   = 3'd3;
	localparam logic [2:0] MODE_SOUND = 3'd4;

	// Motor status codes.
	localparam logic [2:0] ST_OFF       = 3'd0;
	localparam logic [2:0] ST_BRAKE     = 3'd1;
	localparam logic [2:0] ST_FORCED    = 3'd2;
	localparam logic [2:0] ST_AUTO_FREE = 3'd3;
	localparam logic [2:0] ST_AUTO_PID  = 3'd4;
	localparam logic [2:0] ST_SOUND     = 3'd5;

	// Commutation commands.
	localparam logic [1:0] CMD_OFF     = 2'd0;
	localparam logic [1:0] CMD_BRAKE   = 2'd1;
	localparam logic [1:0] CMD_FORCED0 = 2'd2;
	localparam logic [1:0] CMD_SOUND0  = 2'd3;

	// Result item actions.
	localparam logic [1:0] ACT_REPORT = 2'd0;
	localparam logic [1:0] ACT_CMD    = 2'd1;
	localparam logic [1:0] ACT_PWM    = 2'd2;
	localparam logic [1:0] ACT_SOUND  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PWM_FORCED    = 3'd0;
	localparam logic [2:0] CFG_PWM_SOUND     = 3'd1;
	localparam logic [2:0] CFG_PWM_RUN       = 3'd2;
	localparam logic [2:0] CFG_STALL_LIMIT   = 3'd3;
	localparam logic [2:0] CFG_RESTART_LIMIT = 3'd4;

	// Configuration reset values.
	localparam logic [6:0] PWM_FORCED_RST    = 7'd50;
	localparam logic [6:0] PWM_SOUND_RST     = 7'd10;
	localparam logic [6:0] PWM_RUN_RST       = 7'd80;
	localparam logic [7:0] STALL_LIMIT_RST   = 8'd10;
	localparam logic [7:0] RESTART_LIMIT_RST = 8'd3;

	// Forced commutation ramp. The top threshold is wider than the interval
	// itself, so that branch can never be taken.
	localparam logic [12:0] INTERVAL_START = 13'd5000;
	localparam logic [13:0] RAMP_TOP       = 14'd10000;
	localparam logic [12:0] RAMP_MID       = 13'd2000;
	localparam logic [12:0] RAMP_LOW       = 13'd1000;
	localparam logic [12:0] RAMP_END       = 13'd500;
	localparam logic [12:0] STEP_TOP       = 13'd200;
	localparam logic [12:0] STEP_MID       = 13'd100;
	localparam logic [12:0] STEP_LOW       = 13'd50;
	localparam logic [12:0] STEP_END       = 13'd25;

	// Most result slots that one event can fill.
	localparam logic [2:0] ITEM_SLOTS = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  commutation_cmd;
		logic [6:0]  pwm_pct;
		logic [2:0]  motor_state;
		logic [2:0]  cur_mode;
		logic [12:0] interval_now;
		logic        last_item;
	} bldcss_item_t;

	typedef struct packed {
		logic [6:0] pwm_forced_pct;
		logic [6:0] pwm_sound_pct;
		logic [6:0] pwm_run_pct;
		logic [7:0] stall_limit;
		logic [7:0] restart_limit;
	} bldcss_cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  mode_before;
		logic [2:0]  status;
		logic [12:0] interval;
		logic [7:0]  stall_count;
		logic [7:0]  restart_count;
	} bldcss_state_t;

	typedef struct packed {
		logic [2:0]                count;
		bldcss_item_t [4:0]        item;
	} bldcss_list_t;

	typedef struct packed {
		bldcss_state_t st;
		bldcss_list_t  list;
	} bldcss_work_t;

endpackage

FILE: design/bldcss_req_if.sv
interface bldcss_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] new_mode;

	modport source (output valid, output req_type, output new_mode, input ready);
	modport sink (input valid, input req_type, input new_mode, output ready);
endinterface

FILE: design/bldcss_res_if.sv
interface bldcss_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  commutation_cmd;
	logic [6:0]  pwm_pct;
	logic [2:0]  motor_state;
	logic [2:0]  cur_mode;
	logic [12:0] interval_now;
	logic        last_item;

	modport source (
		output valid, output action, output commutation_cmd, output pwm_pct,
		output motor_state, output cur_mode, output interval_now, output last_item,
		input ready
	);
	modport sink (
		input valid, input action, input commutation_cmd, input pwm_pct,
		input motor_state, input cur_mode, input interval_now, input last_item,
		output ready
	);
endinterface

FILE: design/bldcss_cfg_if.sv
interface bldcss_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/bldc_startup_sequencer.sv
// An event is registered into the input stage at its input transfer; once the result
// buffer frees up, the event is processed into it and its first result item is offered;
// the remaining items follow one per cycle while res.ready is high. An event yields one
// to five items through a five-entry result shift buffer; a new event is taken meanwhile.
// Reset (arst_n low, asynchronous): configuration to its defaults, mode, status and
// counters to zero, interval to 5000, input stage and result buffer emptied.
`include "bldc_startup_sequencer_assert.svh"

module bldc_startup_sequencer
	import bldcss_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	bldcss_req_if.sink     req,
	bldcss_res_if.source   res,
	bldcss_cfg_if.sink     cfg
);

	// Append one action item, dropping it if every slot is taken.
	function automatic bldcss_list_t emit(bldcss_list_t l, logic [1:0] act,
		logic [1:0] cmd, logic [6:0] pwm);
		bldcss_list_t r;
		r = l;
		if (l.count < ITEM_SLOTS) begin
			r.item[l.count] = '0;
			r.item[l.count].action = act;
			r.item[l.count].commutation_cmd = cmd;
			r.item[l.count].pwm_pct = pwm;
			r.count = l.count + 3'd1;
		end
		return r;
	endfunction

	// One periodic step of the mode handler.
	function automatic bldcss_work_t task_step(bldcss_work_t w, bldcss_cfg_t c);
		bldcss_work_t r;
		r = w;
		unique case (w.st.mode)
			MODE_OFF: begin
				r.list = emit(r.list, ACT_CMD, CMD_OFF, 7'd0);
				r.st.status = ST_OFF;
			end
			MODE_BRAKE: begin
				r.list = emit(r.list, ACT_CMD, CMD_BRAKE, 7'd0);
				r.st.status = ST_BRAKE;
			end
			MODE_FREE: begin
				// Entering free running from any mode but PID starts the forced ramp.
				if (w.st.mode_before != MODE_FREE && w.st.mode_before != MODE_PID) begin
					r.st.interval = INTERVAL_START;
					r.list = emit(r.list, ACT_CMD, CMD_FORCED0, 7'd0);
					r.list = emit(r.list, ACT_PWM, CMD_OFF, c.pwm_forced_pct);
					r.st.status = ST_FORCED;
					r.st.stall_count = 8'd0;
					r.st.restart_count = 8'd0;
				end
				if (w.st.mode_before == MODE_PID) begin
					r.st.status = ST_AUTO_FREE;
				end
				// Ramp the interval down until automatic running takes over.
				if (r.st.status == ST_FORCED) begin
					if ({1'b0, r.st.interval} > RAMP_TOP) begin
						r.st.interval = r.st.interval - STEP_TOP;
					end else if (r.st.interval > RAMP_MID) begin
						r.st.interval = r.st.interval - STEP_MID;
					end else if (r.st.interval > RAMP_LOW) begin
						r.st.interval = r.st.interval - STEP_LOW;
					end else if (r.st.interval > RAMP_END) begin
						r.st.interval = r.st.interval - STEP_END;
					end else begin
						r.list = emit(r.list, ACT_PWM, CMD_OFF, c.pwm_run_pct);
						r.st.status = ST_AUTO_FREE;
						r.st.stall_count = 8'd0;
					end
				end
			end
			MODE_PID: begin
				r.st.status = ST_AUTO_PID;
			end
			MODE_SOUND: begin
				if (w.st.mode_before != MODE_SOUND) begin
					r.list = emit(r.list, ACT_CMD, CMD_SOUND0, 7'd0);
				end
				r.st.status = ST_SOUND;
			end
			default: begin
				// Invalid modes switch the bridge off and keep the status.
				r.list = emit(r.list, ACT_CMD, CMD_OFF, 7'd0);
			end
		endcase
		r.st.mode_before = w.st.mode;
		return r;
	endfunction

	// Mode change with its PWM set-up, followed by one task step.
	function automatic bldcss_work_t set_mode(bldcss_work_t w, logic [2:0] m,
		bldcss_cfg_t c);
		bldcss_work_t r;
		r = w;
		if ((m == MODE_FREE && w.st.mode != MODE_FREE) ||
			(m == MODE_PID && w.st.mode != MODE_PID)) begin
			r.list = emit(r.list, ACT_PWM, CMD_OFF, c.pwm_forced_pct);
		end else if (m == MODE_SOUND && w.st.mode != MODE_SOUND) begin
			r.list = emit(r.list, ACT_PWM, CMD_OFF, c.pwm_sound_pct);
			r.list = emit(r.list, ACT_SOUND, CMD_OFF, 7'd0);
		end
		r.st.mode = m;
		return task_step(r, c);
	endfunction

	// Stall supervision while running: restart or leave the motor braked.
	function automatic bldcss_work_t timeout_tick(bldcss_work_t w, bldcss_cfg_t c);
		bldcss_work_t r;
		r = w;
		if (w.st.mode == MODE_FREE || w.st.mode == MODE_PID) begin
			if (w.st.stall_count >= c.stall_limit) begin
				if (w.st.restart_count < c.restart_limit) begin
					r = set_mode(r, MODE_BRAKE, c);
					r = set_mode(r, MODE_FREE, c);
					r.st.stall_count = 8'd0;
					r.st.restart_count = r.st.restart_count + 8'd1;
				end else begin
					r = set_mode(r, MODE_BRAKE, c);
				end
			end else begin
				r.st.stall_count = w.st.stall_count + 8'd1;
			end
		end
		return r;
	endfunction

	bldcss_cfg_t   cfg_q;
	bldcss_state_t state_q;
	logic          req_valid_s1;
	logic [1:0]    req_type_s1;
	logic [2:0]    new_mode_s1;
	bldcss_item_t  items_q [5];
	logic [2:0]    res_cnt_q;

	bldcss_work_t  work;
	bldcss_work_t  start;
	logic          load;
	logic          res_xfer;

	// Configuration writes are always taken; unknown indexes are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_forced_pct <= PWM_FORCED_RST;
			cfg_q.pwm_sound_pct <= PWM_SOUND_RST;
			cfg_q.pwm_run_pct <= PWM_RUN_RST;
			cfg_q.stall_limit <= STALL_LIMIT_RST;
			cfg_q.restart_limit <= RESTART_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PWM_FORCED:    cfg_q.pwm_forced_pct <= cfg.data[6:0];
				CFG_PWM_SOUND:     cfg_q.pwm_sound_pct <= cfg.data[6:0];
				CFG_PWM_RUN:       cfg_q.pwm_run_pct <= cfg.data[6:0];
				CFG_STALL_LIMIT:   cfg_q.stall_limit <= cfg.data;
				CFG_RESTART_LIMIT: cfg_q.restart_limit <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// The registered event is processed once the result buffer frees up.
	assign res_xfer = res.valid && res.ready;
	assign load = req_valid_s1 && (res_cnt_q == 3'd0 || (res_cnt_q == 3'd1 && res.ready));
	assign req.ready = !req_valid_s1 || load;

	// Event handling on the registered request and the current state.
	always_comb begin
		start.st = state_q;
		start.list = '0;
		unique case (req_type_s1)
			REQ_SET_MODE: work = set_mode(start, new_mode_s1, cfg_q);
			REQ_TASK:     work = task_step(start, cfg_q);
			REQ_TIMEOUT:  work = timeout_tick(start, cfg_q);
			REQ_CLEAR: begin
				work = start;
				work.st.stall_count = 8'd0;
			end
			default:      work = start;
		endcase
		// The status report closes every event.
		if (work.list.count < ITEM_SLOTS) begin
			work.list.item[work.list.count] = '0;
			work.list.item[work.list.count].action = ACT_REPORT;
			work.list.item[work.list.count].motor_state = work.st.status;
			work.list.item[work.list.count].cur_mode = work.st.mode;
			work.list.item[work.list.count].interval_now = work.st.interval;
			work.list.item[work.list.count].last_item = 1'b1;
			work.list.count = work.list.count + 3'd1;
		end
	end

	// Input stage control and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			res_cnt_q <= 3'd0;
			state_q.mode <= MODE_OFF;
			state_q.mode_before <= MODE_OFF;
			state_q.status <= ST_OFF;
			state_q.interval <= INTERVAL_START;
			state_q.stall_count <= 8'd0;
			state_q.restart_count <= 8'd0;
		end else begin
			if (req.valid && req.ready) begin
				req_valid_s1 <= 1'b1;
			end else if (load) begin
				req_valid_s1 <= 1'b0;
			end
			if (load) begin
				state_q <= work.st;
				res_cnt_q <= work.list.count;
			end else if (res_xfer) begin
				res_cnt_q <= res_cnt_q - 3'd1;
			end
		end
	end

	// Payload registers: request capture and the result shift buffer.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			new_mode_s1 <= req.new_mode;
		end
		if (load) begin
			for (int i = 0; i < 5; i++) begin
				items_q[i] <= work.list.item[i];
			end
		end else if (res_xfer) begin
			for (int i = 0; i < 4; i++) begin
				items_q[i] <= items_q[i + 1];
			end
		end
	end

	// The head of the buffer drives the result channel.
	assign res.valid = (res_cnt_q != 3'd0);
	assign res.action = items_q[0].action;
	assign res.commutation_cmd = items_q[0].commutation_cmd;
	assign res.pwm_pct = items_q[0].pwm_pct;
	assign res.motor_state = items_q[0].motor_state;
	assign res.cur_mode = items_q[0].cur_mode;
	assign res.interval_now = items_q[0].interval_now;
	assign res.last_item = items_q[0].last_item;

	// Buffer holds at most one event's worth of items.
	`BLDCSS_ASSERT_NOW(a_cnt_bound, 1'b1, res_cnt_q <= ITEM_SLOTS, "result count overflow")
	// The final buffered item is the status report, and only that one.
	`BLDCSS_ASSERT_NOW(a_last_at_end, res_cnt_q == 3'd1, items_q[0].last_item, "report not last")
	`BLDCSS_ASSERT_NOW(a_last_early, res_cnt_q > 3'd1, !items_q[0].last_item, "report too early")
	// An event's items follow without a gap once started.
	`BLDCSS_ASSERT_NEXT(a_no_gap, res_xfer && !res.last_item, res.valid, "gap inside an event")
	// The forced interval never rises above its start value.
	`BLDCSS_ASSERT_NOW(a_interval, 1'b1, state_q.interval <= INTERVAL_START, "interval too high")

endmodule

FILE: bench/tb_bldc_startup_sequencer.sv
`timescale 1ns / 1ps

module tb_bldc_startup_sequencer;
	import bldcss_pkg::*;

	// Register index that the block does not decode.
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	// Cycles without any transfer before the run is abandoned.
	localparam int unsigned QUIET_LIMIT = 2000;
	// Cycles allowed for the block to drain once nothing is outstanding.
	localparam int unsigned SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] mode;
	} seq_event_t;

	logic clk;
	logic arst_n;

	bldcss_req_if req_if();
	bldcss_res_if res_if();
	bldcss_cfg_if cfg_if();

	bldc_startup_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	// Events waiting to be offered, and result items the sequencer still owes.
	seq_event_t   event_queue[$];
	bldcss_item_t due_items[$];

	// Shadow of the sequencer state.
	logic [2:0]  seq_mode;
	logic [2:0]  seq_mode_before;
	logic [2:0]  seq_status;
	logic [12:0] seq_interval;
	logic [7:0]  seq_stall;
	logic [7:0]  seq_restart;

	// Shadow of the configuration registers.
	logic [6:0] duty_forced;
	logic [6:0] duty_sound;
	logic [6:0] duty_run;
	logic [7:0] stall_limit;
	logic [7:0] restart_limit;

	int unsigned slot_count;
	int unsigned queued_count = 0;
	int unsigned events_sent = 0;
	int unsigned items_checked = 0;
	int unsigned cfg_writes = 0;
	int unsigned settings_used = 0;
	int unsigned ramps_completed = 0;
	int unsigned stall_restarts = 0;
	int unsigned stall_brakes = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_len;
	bit          steady = 1'b0;

	seq_event_t   next_event;
	bldcss_item_t seen_item;
	bldcss_item_t owed_item;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Length of an idle stretch: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (steady)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// An action item; the status fields stay zero.
	function automatic void push_action(logic [1:0] act, logic [1:0] cmd, logic [6:0] pwm);
		bldcss_item_t it;
		if (slot_count >= ITEM_SLOTS)
			return;
		it = '0;
		it.action = act;
		it.commutation_cmd = cmd;
		it.pwm_pct = pwm;
		due_items.push_back(it);
		slot_count++;
	endfunction

	// The closing status report of an event.
	function automatic void push_status();
		bldcss_item_t it;
		if (slot_count >= ITEM_SLOTS)
			return;
		it = '0;
		it.action = ACT_REPORT;
		it.motor_state = seq_status;
		it.cur_mode = seq_mode;
		it.interval_now = seq_interval;
		it.last_item = 1'b1;
		due_items.push_back(it);
		slot_count++;
	endfunction

	// One pass of the motor task in the current mode.
	function automatic void run_task_step();
		case (seq_mode)
			MODE_OFF: begin
				push_action(ACT_CMD, CMD_OFF, 7'd0);
				seq_status = ST_OFF;
			end
			MODE_BRAKE: begin
				push_action(ACT_CMD, CMD_BRAKE, 7'd0);
				seq_status = ST_BRAKE;
			end
			MODE_FREE: begin
				// A fresh start-up restarts the ramp from the top.
				if (seq_mode_before != MODE_FREE && seq_mode_before != MODE_PID) begin
					seq_interval = INTERVAL_START;
					push_action(ACT_CMD, CMD_FORCED0, 7'd0);
					push_action(ACT_PWM, CMD_OFF, duty_forced);
					seq_status = ST_FORCED;
					seq_stall = '0;
					seq_restart = '0;
				end
				if (seq_mode_before == MODE_PID)
					seq_status = ST_AUTO_FREE;
				// Ramp the forced interval down, then hand over to automatic running.
				if (seq_status == ST_FORCED) begin
					if (seq_interval > RAMP_TOP)
						seq_interval = seq_interval - STEP_TOP;
					else if (seq_interval > RAMP_MID)
						seq_interval = seq_interval - STEP_MID;
					else if (seq_interval > RAMP_LOW)
						seq_interval = seq_interval - STEP_LOW;
					else if (seq_interval > RAMP_END)
						seq_interval = seq_interval - STEP_END;
					else begin
						push_action(ACT_PWM, CMD_OFF, duty_run);
						seq_status = ST_AUTO_FREE;
						seq_stall = '0;
						ramps_completed++;
					end
				end
			end
			MODE_PID: begin
				seq_status = ST_AUTO_PID;
			end
			MODE_SOUND: begin
				if (seq_mode_before != MODE_SOUND)
					push_action(ACT_CMD, CMD_SOUND0, 7'd0);
				seq_status = ST_SOUND;
			end
			default: begin
				// An invalid mode switches commutation off and keeps the status.
				push_action(ACT_CMD, CMD_OFF, 7'd0);
			end
		endcase
		seq_mode_before = seq_mode;
	endfunction

	// Mode change followed by one task pass.
	function automatic void enter_mode(logic [2:0] m);
		if ((m == MODE_FREE && seq_mode != MODE_FREE) ||
			(m == MODE_PID && seq_mode != MODE_PID)) begin
			push_action(ACT_PWM, CMD_OFF, duty_forced);
		end else if (m == MODE_SOUND && seq_mode != MODE_SOUND) begin
			push_action(ACT_PWM, CMD_OFF, duty_sound);
			push_action(ACT_SOUND, CMD_OFF, 7'd0);
		end
		seq_mode = m;
		run_task_step();
	endfunction

	// Stall supervision on a timeout tick.
	function automatic void handle_timeout();
		if (seq_mode != MODE_FREE && seq_mode != MODE_PID)
			return;
		if (seq_stall >= stall_limit) begin
			if (seq_restart < restart_limit) begin
				enter_mode(MODE_BRAKE);
				enter_mode(MODE_FREE);
				seq_stall = '0;
				seq_restart = seq_restart + 8'd1;
				stall_restarts++;
			end else begin
				enter_mode(MODE_BRAKE);
				stall_brakes++;
			end
		end else begin
			seq_stall = seq_stall + 8'd1;
		end
	endfunction

	// Work out every result item that one accepted event causes.
	function automatic void advance_sequencer(logic [1:0] kind, logic [2:0] mode);
		slot_count = 0;
		case (kind)
			REQ_SET_MODE: enter_mode(mode);
			REQ_TASK:     run_task_step();
			REQ_TIMEOUT:  handle_timeout();
			default:      seq_stall = '0;
		endcase
		push_status();
	endfunction

	function automatic void queue_event(logic [1:0] kind, logic [2:0] mode);
		seq_event_t ev;
		ev.kind = kind;
		ev.mode = mode;
		event_queue.push_back(ev);
		queued_count++;
	endfunction

	// Request driver: offers queued events with random gaps between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.req_type <= REQ_SET_MODE;
			req_if.new_mode <= MODE_OFF;
			gap_left <= 0;
			seq_mode = MODE_OFF;
			seq_mode_before = MODE_OFF;
			seq_status = ST_OFF;
			seq_interval = INTERVAL_START;
			seq_stall = '0;
			seq_restart = '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				advance_sequencer(req_if.req_type, req_if.new_mode);
				events_sent++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_if.valid <= 1'b0;
				end else if (event_queue.size() > 0) begin
					next_event = event_queue.pop_front();
					req_if.valid <= 1'b1;
					req_if.req_type <= next_event.kind;
					req_if.new_mode <= next_event.mode;
					gap_left <= idle_len();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer against the oldest owed item.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				seen_item.action = res_if.action;
				seen_item.commutation_cmd = res_if.commutation_cmd;
				seen_item.pwm_pct = res_if.pwm_pct;
				seen_item.motor_state = res_if.motor_state;
				seen_item.cur_mode = res_if.cur_mode;
				seen_item.interval_now = res_if.interval_now;
				seen_item.last_item = res_if.last_item;
				if (due_items.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"Unexpected result item: act=%0d cmd=%0d pwm=%0d ",
							"st=%0d mode=%0d int=%0d last=%0d"},
							seen_item.action, seen_item.commutation_cmd, seen_item.pwm_pct,
							seen_item.motor_state, seen_item.cur_mode, seen_item.interval_now,
							seen_item.last_item);
				end else begin
					owed_item = due_items.pop_front();
					if (seen_item.action !== owed_item.action ||
						seen_item.commutation_cmd !== owed_item.commutation_cmd ||
						seen_item.pwm_pct !== owed_item.pwm_pct ||
						seen_item.motor_state !== owed_item.motor_state ||
						seen_item.cur_mode !== owed_item.cur_mode ||
						seen_item.interval_now !== owed_item.interval_now ||
						seen_item.last_item !== owed_item.last_item) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"Mismatch on result %0d: expected act=%0d cmd=%0d pwm=%0d st=%0d ",
								"mode=%0d int=%0d last=%0d, got act=%0d cmd=%0d pwm=%0d st=%0d ",
								"mode=%0d int=%0d last=%0d"}, items_checked,
								owed_item.action, owed_item.commutation_cmd, owed_item.pwm_pct,
								owed_item.motor_state, owed_item.cur_mode, owed_item.interval_now,
								owed_item.last_item, seen_item.action, seen_item.commutation_cmd,
								seen_item.pwm_pct, seen_item.motor_state, seen_item.cur_mode,
								seen_item.interval_now, seen_item.last_item);
					end
					items_checked++;
				end
			end
			// Back-pressure on the result side.
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res_if.ready <= 1'b0;
			end else begin
				hold_len = ($urandom_range(3) == 0) ? idle_len() : 0;
				if (hold_len == 0) begin
					res_if.ready <= 1'b1;
				end else begin
					res_if.ready <= 1'b0;
					stall_left <= hold_len - 1;
				end
			end
		end
	end

	// Watchdog: a long stretch with no transfer on any channel ends the run.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("No transfer for %0d cycles; %0d result items still owed",
					QUIET_LIMIT, due_items.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// One register write; returns at the edge of its transfer.
	task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_PWM_FORCED:    duty_forced = val[6:0];
			CFG_PWM_SOUND:     duty_sound = val[6:0];
			CFG_PWM_RUN:       duty_run = val[6:0];
			CFG_STALL_LIMIT:   stall_limit = val;
			CFG_RESTART_LIMIT: restart_limit = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Rewrites every register while the sequencer is idle.
	task automatic write_settings(input logic [7:0] forced, input logic [7:0] sound,
		input logic [7:0] run, input logic [7:0] stall, input logic [7:0] restart,
		input bit with_unused);
		@(posedge clk);
		cfg_write(CFG_PWM_FORCED, forced);
		cfg_write(CFG_PWM_SOUND, sound);
		cfg_write(CFG_PWM_RUN, run);
		cfg_write(CFG_STALL_LIMIT, stall);
		cfg_write(CFG_RESTART_LIMIT, restart);
		if (with_unused)
			cfg_write(CFG_UNUSED, 8'h5A);
		cfg_if.valid <= 1'b0;
		settings_used++;
		@(negedge clk);
	endtask

	// Waits until every event is taken and every owed item has arrived.
	task automatic wait_idle();
		@(negedge clk);
		while (event_queue.size() != 0 || req_if.valid || due_items.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random traffic, mostly well-formed start-up, stall and sound sequences.
	task automatic gen_random(input int unsigned budget);
		int unsigned target;
		int unsigned pick;
		int unsigned n;
		int unsigned r;
		int unsigned i;
		bit          long_run;
		target = queued_count + budget;
		while (queued_count < target) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				// Start-up from rest, then a run of task ticks through the ramp.
				queue_event(REQ_SET_MODE, ($urandom_range(1) == 0) ? MODE_OFF : MODE_BRAKE);
				queue_event(REQ_SET_MODE, MODE_FREE);
				long_run = ($urandom_range(2) == 0);
				n = long_run ? $urandom_range(72, 84) : $urandom_range(4, 30);
				for (i = 0; i < n; i++) begin
					r = $urandom_range(99);
					if (r < (long_run ? 2 : 8))
						queue_event(REQ_TIMEOUT, 3'($urandom_range(7)));
					else if (r < (long_run ? 6 : 12))
						queue_event(REQ_CLEAR, 3'($urandom_range(7)));
					else
						queue_event(REQ_TASK, 3'($urandom_range(7)));
				end
			end else if (pick < 55) begin
				// Enough timeout ticks to reach the stall limit where it is small.
				if ($urandom_range(1) == 0)
					queue_event(REQ_SET_MODE, ($urandom_range(1) == 0) ? MODE_FREE : MODE_PID);
				n = ((stall_limit > 8'd20) ? 20 : stall_limit) + $urandom_range(1, 3);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(99) < 6)
						queue_event(REQ_CLEAR, 3'($urandom_range(7)));
					else
						queue_event(REQ_TIMEOUT, 3'($urandom_range(7)));
				end
			end else if (pick < 70) begin
				queue_event(REQ_SET_MODE, MODE_SOUND);
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					queue_event(REQ_TASK, 3'($urandom_range(7)));
				if ($urandom_range(1) == 0)
					queue_event(REQ_SET_MODE, MODE_SOUND);
			end else if (pick < 80) begin
				queue_event(REQ_SET_MODE, 3'($urandom_range(7)));
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					queue_event(REQ_TASK, 3'($urandom_range(7)));
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					queue_event(2'($urandom_range(3)), 3'($urandom_range(7)));
			end
		end
	endtask

	// Stimulus sequencing.
	initial begin
		int unsigned phase;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_PWM_FORCED;
		cfg_if.data = '0;
		duty_forced = PWM_FORCED_RST;
		duty_sound = PWM_SOUND_RST;
		duty_run = PWM_RUN_RST;
		stall_limit = STALL_LIMIT_RST;
		restart_limit = RESTART_LIMIT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: every mode, invalid modes and the return from PID.
		queue_event(REQ_TASK, 3'd7);
		queue_event(REQ_SET_MODE, MODE_BRAKE);
		queue_event(REQ_SET_MODE, MODE_SOUND);
		queue_event(REQ_TASK, 3'd0);
		queue_event(REQ_SET_MODE, MODE_SOUND);
		queue_event(REQ_SET_MODE, MODE_PID);
		queue_event(REQ_TIMEOUT, 3'd5);
		queue_event(REQ_SET_MODE, MODE_FREE);
		queue_event(REQ_CLEAR, 3'd7);
		queue_event(REQ_SET_MODE, 3'd5);
		queue_event(REQ_TASK, 3'd2);
		queue_event(REQ_SET_MODE, 3'd7);
		queue_event(REQ_SET_MODE, MODE_OFF);
		queue_event(REQ_SET_MODE, MODE_FREE);
		queue_event(REQ_SET_MODE, MODE_FREE);
		wait_idle();

		// Zero limits: the first timeout brakes, later ones do nothing.
		write_settings(8'd0, 8'hFF, 8'd100, 8'd0, 8'd0, 1'b1);
		queue_event(REQ_SET_MODE, MODE_FREE);
		queue_event(REQ_TIMEOUT, 3'd0);
		queue_event(REQ_TIMEOUT, 3'd7);
		queue_event(REQ_SET_MODE, MODE_SOUND);
		wait_idle();

		// One restart allowed: a restart from PID, then a brake.
		write_settings(8'h7F, 8'd0, 8'd0, 8'd1, 8'd1, 1'b0);
		queue_event(REQ_SET_MODE, MODE_PID);
		queue_event(REQ_TIMEOUT, 3'd1);
		queue_event(REQ_TIMEOUT, 3'd2);
		queue_event(REQ_TIMEOUT, 3'd4);
		queue_event(REQ_TIMEOUT, 3'd6);
		wait_idle();

		// Random phases under varied register settings.
		for (phase = 0; phase < 5; phase++) begin
			if (phase == 1)
				write_settings(8'd100, 8'd100, 8'hFF, 8'hFF, 8'hFF, 1'b0);
			else
				write_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(0, 6)),
					8'($urandom_range(0, 3)), 1'b0);
			steady = (phase == 2) || ($urandom_range(3) == 0);
			gen_random(48);
			wait_idle();
		end
		repeat (20) @(negedge clk);

		if (due_items.size() != 0)
			$display("%0d result items never arrived", due_items.size());
		$display("Covered %0d events and %0d result items under %0d register settings",
			events_sent, items_checked, settings_used);
		$display("(%0d writes); ramps run to automatic running: %0d, stall restarts: %0d, %s%0d.",
			cfg_writes, ramps_completed, stall_restarts, "stall brakes: ", stall_brakes);
		if (fail_count == 0 && due_items.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: bldc_startup_sequencer.f
+incdir+design
design/bldcss_pkg.sv
design/bldcss_req_if.sv
design/bldcss_res_if.sv
design/bldcss_cfg_if.sv
design/bldc_startup_sequencer.sv
bench/tb_bldc_startup_sequencer.sv
